### rtl/core/dead_reckoning_pose_integrator_top_assert.svh
// assertion macros shared by the pose integrator rtl
`ifndef DEAD_RECKONING_POSE_INTEGRATOR_TOP_ASSERT_SVH
`define DEAD_RECKONING_POSE_INTEGRATOR_TOP_ASSERT_SVH

// implication checked in the same cycle
`define DRPI_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle
`define DRPI_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/drpi_pkg.sv
// shared types, constants and tables for the pose integrator
package drpi_pkg;

  // cordic and arithmetic sizes
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int STEP_W           = 5;
  localparam int POS_W            = 48;
  localparam int MAG_W            = 32;
  localparam int HEAD_W           = 32;
  localparam int TRIG_W           = 34;
  localparam int PROD_W           = 66;
  localparam int ATAN_W           = 30;
  localparam int DIV_DIGITS       = 24;

  // configuration port
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int REG_SEL_BIT = 3;
  localparam logic REG_START_X = 1'b0;
  localparam logic REG_START_Y = 1'b1;

  // command kinds and units
  localparam logic [1:0] MODE_ADVANCE  = 2'd0;
  localparam logic [1:0] MODE_TURN     = 2'd1;
  localparam logic [1:0] MODE_ANALYSIS = 2'd2;
  localparam logic [1:0] UNIT_M        = 2'd0;
  localparam logic [1:0] UNIT_CM       = 2'd1;
  localparam logic [1:0] UNIT_DM       = 2'd2;
  localparam logic [1:0] UNIT_KM       = 2'd3;
  localparam logic [1:0] TURN_DEG      = 2'd1;

  // cordic start vector, 1/K in Q30
  localparam logic signed [TRIG_W-1:0] INV_GAIN_Q30 = 34'sd652032874;

  // radians to binary angle, round(2^47/pi), split for two narrow products
  localparam int RAD_W     = 46;
  localparam int RAD_SPLIT = 23;
  localparam logic [RAD_W-1:0] RAD_TO_BAM = 46'd44798133900177;

  // reciprocals floor(2^33/d) for the cm and dm divisions
  localparam int RECIP_SHIFT = 33;
  localparam logic [29:0] RECIP_100 = 30'd85899345;
  localparam logic [29:0] RECIP_10  = 30'd858993459;
  localparam logic [6:0]  DIV_CM    = 7'd100;
  localparam logic [6:0]  DIV_DM    = 7'd10;

  // degree turn divider, dividend rounded by half of 360
  localparam logic [47:0] DEG_RND  = 48'd180;
  localparam logic [10:0] DEG_DIV1 = 11'd360;
  localparam logic [10:0] DEG_DIV2 = 11'd720;
  localparam logic [10:0] DEG_DIV3 = 11'd1080;

  // position limits
  localparam logic signed [POS_W-1:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [MAG_W-1:0] magnitude;
    logic [1:0]              unit;
    logic                    restart;
  } in_word_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [HEAD_W-1:0]       heading_angle;
    logic                    saturated;
  } out_word_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CINIT,
    OP_CSTEP,
    OP_MUL,
    OP_ABS,
    OP_RND,
    OP_DIV,
    OP_FIX,
    OP_ACC,
    OP_RLO,
    OP_RHI,
    OP_RADD,
    OP_DINIT,
    OP_DSTEP,
    OP_DADD,
    OP_PUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic              axis;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] unit;
  } dp_stat_t;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [ATAN_W-1:0] atan_bam(input logic [STEP_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/drpi_dp.sv
// pose integrator datapath: pose registers, cordic, scaling and turn units
module drpi_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  drpi_pkg::dp_cmd_t          cmd,
  input  drpi_pkg::in_word_t         in_word,
  input  logic signed [47:0]         start_x,
  input  logic signed [47:0]         start_y,
  output drpi_pkg::dp_stat_t         stat,
  output drpi_pkg::out_word_t        out_word
);
  import drpi_pkg::*;

  // pose state
  logic signed [POS_W-1:0]  x_pos_r, y_pos_r;
  logic [HEAD_W-1:0]        head_r;
  logic                     sat_r;

  // latched command
  logic signed [MAG_W-1:0]  mag_r;
  logic [1:0]               mode_r, unit_r;

  // cordic vector
  logic signed [TRIG_W-1:0] cx_r, cy_r, cz_r;
  logic                     flip_r;

  // scaling pipeline registers
  logic signed [PROD_W-1:0] prod_r;
  logic [63:0]              aux_r;
  logic [63:0]              u_r;
  logic                     neg_r;
  logic [43:0]              b_r;
  logic [52:0]              stage_r;
  logic [42:0]              q_r;

  // degree divider
  logic [47:0]              dq_r;
  logic [8:0]               rem_r;

  out_word_t                out_word_r;

  // shared multiplier operand select
  logic signed [TRIG_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    case (cmd.op)
      OP_RLO:  mul_b = $signed({{(TRIG_W-RAD_SPLIT){1'b0}}, RAD_TO_BAM[RAD_SPLIT-1:0]});
      OP_RHI:  mul_b = $signed({{(TRIG_W-(RAD_W-RAD_SPLIT)){1'b0}},
                                RAD_TO_BAM[RAD_W-1:RAD_SPLIT]});
      default: mul_b = cmd.axis ? cy_r : cx_r;
    endcase
  end

  assign mul_p = PROD_W'(mag_r) * PROD_W'(mul_b);

  // cordic micro-rotation
  logic signed [TRIG_W-1:0] sh_x, sh_y, at_ext;
  logic                     ang_flip;
  logic [HEAD_W-1:0]        ang_adj;

  assign sh_x     = cx_r >>> cmd.step;
  assign sh_y     = cy_r >>> cmd.step;
  assign at_ext   = $signed({{(TRIG_W-ATAN_W){1'b0}}, atan_bam(cmd.step)});
  assign ang_flip = head_r[HEAD_W-1] ^ head_r[HEAD_W-2];
  assign ang_adj  = {head_r[HEAD_W-1] ^ ang_flip, head_r[HEAD_W-2:0]};

  // rounding add before the unit shift
  logic [63:0] rnd_add, rnd_sum;
  logic [43:0] b_nxt;

  always_comb begin
    case (unit_r)
      UNIT_M:  rnd_add = 64'd1 << 29;
      UNIT_CM: rnd_add = 64'd50 << 30;
      UNIT_DM: rnd_add = 64'd5 << 30;
      UNIT_KM: rnd_add = 64'd1 << 19;
      default: rnd_add = 64'd0;
    endcase
    rnd_sum = u_r + rnd_add;
    if (unit_r == UNIT_KM) begin
      b_nxt = 44'(rnd_sum >> 20);
    end else begin
      b_nxt = 44'(rnd_sum >> 30);
    end
  end

  // constant division by reciprocal, km scaling
  logic [29:0] recip_m;
  logic [62:0] recip_p;
  logic [52:0] km_p;
  logic [52:0] stage_nxt;

  always_comb begin
    recip_m = (unit_r == UNIT_CM) ? RECIP_100 : RECIP_10;
    recip_p = 63'(b_r[32:0]) * 63'(recip_m);
    km_p    = 53'(b_r[41:0]) * 53'd1000 + 53'd512;
    case (unit_r)
      UNIT_M:           stage_nxt = 53'(b_r);
      UNIT_CM, UNIT_DM: stage_nxt = 53'(recip_p >> RECIP_SHIFT);
      UNIT_KM:          stage_nxt = km_p;
      default:          stage_nxt = 53'(b_r);
    endcase
  end

  // quotient correction, at most one step
  logic [32:0] qm, fix_q;
  logic [6:0]  dv;
  logic [39:0] qd;
  logic [40:0] rem_fix;
  logic [42:0] q_nxt;

  always_comb begin
    qm      = stage_r[32:0];
    dv      = (unit_r == UNIT_CM) ? DIV_CM : DIV_DM;
    qd      = 40'(qm) * 40'(dv);
    rem_fix = {1'b0, b_r[39:0]} - {1'b0, qd};
    fix_q   = (rem_fix >= 41'(dv)) ? qm + 33'd1 : qm;
    case (unit_r)
      UNIT_M:           q_nxt = stage_r[42:0];
      UNIT_CM, UNIT_DM: q_nxt = 43'(fix_q);
      UNIT_KM:          q_nxt = 43'(stage_r >> 10);
      default:          q_nxt = stage_r[42:0];
    endcase
  end

  // saturating position update
  logic signed [43:0]      delta;
  logic signed [49:0]      acc_sum;
  logic signed [POS_W-1:0] acc_pos, acc_val;
  logic                    clip_hi, clip_lo;

  always_comb begin
    delta   = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    acc_pos = cmd.axis ? y_pos_r : x_pos_r;
    acc_sum = $signed({{2{acc_pos[POS_W-1]}}, acc_pos}) + $signed({{6{delta[43]}}, delta});
    clip_hi = !acc_sum[49] && (acc_sum[48:47] != 2'b00);
    clip_lo = acc_sum[49] && (acc_sum[48:47] != 2'b11);
    if (clip_hi) begin
      acc_val = POS_MAX;
    end else if (clip_lo) begin
      acc_val = POS_MIN;
    end else begin
      acc_val = acc_sum[POS_W-1:0];
    end
  end

  // radian turn sum, modulo 2^64
  logic [63:0] rad_sum;
  assign rad_sum = (prod_r[63:0] << RAD_SPLIT) + aux_r;

  // radix-4 digit of the degree divider
  logic [10:0] dig_rr, dig_sub;
  logic [1:0]  dig;
  logic [31:0] abs_mag;
  logic [31:0] deg_q;

  always_comb begin
    dig_rr = {rem_r, dq_r[47:46]};
    if (dig_rr >= DEG_DIV3) begin
      dig     = 2'd3;
      dig_sub = DEG_DIV3;
    end else if (dig_rr >= DEG_DIV2) begin
      dig     = 2'd2;
      dig_sub = DEG_DIV2;
    end else if (dig_rr >= DEG_DIV1) begin
      dig     = 2'd1;
      dig_sub = DEG_DIV1;
    end else begin
      dig     = 2'd0;
      dig_sub = 11'd0;
    end
    abs_mag = mag_r[MAG_W-1] ? 32'(-mag_r) : 32'(mag_r);
    deg_q   = neg_r ? (32'd0 - dq_r[31:0]) : dq_r[31:0];
  end

  // pose registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_pos_r <= '0;
      y_pos_r <= '0;
      head_r  <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          if (in_word.restart) begin
            x_pos_r <= start_x;
            y_pos_r <= start_y;
            head_r  <= '0;
          end
        end
        OP_ACC: begin
          if (cmd.axis) begin
            y_pos_r <= acc_val;
          end else begin
            x_pos_r <= acc_val;
          end
        end
        OP_RADD: head_r <= head_r + rad_sum[63:32];
        OP_DADD: head_r <= head_r + deg_q;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mag_r  <= in_word.magnitude;
        mode_r <= in_word.mode;
        unit_r <= in_word.unit;
        sat_r  <= 1'b0;
      end
      OP_CINIT: begin
        cx_r   <= INV_GAIN_Q30;
        cy_r   <= '0;
        cz_r   <= TRIG_W'($signed(ang_adj));
        flip_r <= ang_flip;
      end
      OP_CSTEP: begin
        if (!cz_r[TRIG_W-1]) begin
          cx_r <= cx_r - sh_y;
          cy_r <= cy_r + sh_x;
          cz_r <= cz_r - at_ext;
        end else begin
          cx_r <= cx_r + sh_y;
          cy_r <= cy_r - sh_x;
          cz_r <= cz_r + at_ext;
        end
      end
      OP_MUL, OP_RLO: prod_r <= mul_p;
      OP_RHI: begin
        aux_r  <= prod_r[63:0] + 64'h8000_0000;
        prod_r <= mul_p;
      end
      OP_ABS: begin
        u_r   <= prod_r[PROD_W-1] ? 64'(-prod_r) : 64'(prod_r);
        neg_r <= prod_r[PROD_W-1] ^ flip_r;
      end
      OP_RND: b_r     <= b_nxt;
      OP_DIV: stage_r <= stage_nxt;
      OP_FIX: q_r     <= q_nxt;
      OP_ACC: sat_r   <= sat_r | clip_hi | clip_lo;
      OP_DINIT: begin
        neg_r <= mag_r[MAG_W-1];
        dq_r  <= {abs_mag, 16'd0} + DEG_RND;
        rem_r <= '0;
      end
      OP_DSTEP: begin
        rem_r <= 9'(dig_rr - dig_sub);
        dq_r  <= {dq_r[45:0], dig};
      end
      OP_PUT: begin
        out_word_r.pos_x         <= x_pos_r;
        out_word_r.pos_y         <= y_pos_r;
        out_word_r.heading_angle <= head_r;
        out_word_r.saturated     <= sat_r;
      end
      default: ;
    endcase
  end

  assign stat.mode = mode_r;
  assign stat.unit = unit_r;
  assign out_word  = out_word_r;

endmodule

### rtl/core/drpi_ctrl.sv
// pose integrator controller: command sequencing and result handshake
`include "dead_reckoning_pose_integrator_top_assert.svh"

module drpi_ctrl #(
  parameter int CORDIC_STEPS = drpi_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  drpi_pkg::dp_stat_t stat,
  output drpi_pkg::dp_cmd_t  cmd
);
  import drpi_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [STEP_W-1:0] LAST_DIGIT = STEP_W'(DIV_DIGITS - 1);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_CINIT,
    S_CSTEP,
    S_MUL,
    S_ABS,
    S_RND,
    S_DIV,
    S_FIX,
    S_ACC,
    S_RLO,
    S_RHI,
    S_RADD,
    S_DINIT,
    S_DSTEP,
    S_DADD,
    S_PUT
  } state_t;

  state_t            state_r;
  logic [STEP_W-1:0] step_r;
  logic              axis_r;
  logic              out_valid_r;

  logic accept, out_free, put;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign put      = (state_r == S_PUT) && out_free;

  // decode state into a datapath operation
  always_comb begin
    cmd.axis = axis_r;
    cmd.step = step_r;
    case (state_r)
      S_IDLE:  cmd.op = accept ? OP_LOAD : OP_NONE;
      S_CINIT: cmd.op = OP_CINIT;
      S_CSTEP: cmd.op = OP_CSTEP;
      S_MUL:   cmd.op = OP_MUL;
      S_ABS:   cmd.op = OP_ABS;
      S_RND:   cmd.op = OP_RND;
      S_DIV:   cmd.op = OP_DIV;
      S_FIX:   cmd.op = OP_FIX;
      S_ACC:   cmd.op = OP_ACC;
      S_RLO:   cmd.op = OP_RLO;
      S_RHI:   cmd.op = OP_RHI;
      S_RADD:  cmd.op = OP_RADD;
      S_DINIT: cmd.op = OP_DINIT;
      S_DSTEP: cmd.op = OP_DSTEP;
      S_DADD:  cmd.op = OP_DADD;
      S_PUT:   cmd.op = put ? OP_PUT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  // state, counters and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (put) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (stat.mode)
            MODE_ADVANCE:  state_r <= S_CINIT;
            MODE_TURN:     state_r <= (stat.unit == TURN_DEG) ? S_DINIT : S_RLO;
            MODE_ANALYSIS: state_r <= S_PUT;
            default:       state_r <= S_PUT;
          endcase
        end
        S_CINIT: begin
          step_r  <= '0;
          state_r <= S_CSTEP;
        end
        S_CSTEP: begin
          if (step_r == LAST_STEP) begin
            axis_r  <= 1'b0;
            state_r <= S_MUL;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_MUL: state_r <= S_ABS;
        S_ABS: state_r <= S_RND;
        S_RND: state_r <= S_DIV;
        S_DIV: state_r <= S_FIX;
        S_FIX: state_r <= S_ACC;
        S_ACC: begin
          if (!axis_r) begin
            axis_r  <= 1'b1;
            state_r <= S_MUL;
          end else begin
            state_r <= S_PUT;
          end
        end
        S_RLO:  state_r <= S_RHI;
        S_RHI:  state_r <= S_RADD;
        S_RADD: state_r <= S_PUT;
        S_DINIT: begin
          step_r  <= '0;
          state_r <= S_DSTEP;
        end
        S_DSTEP: begin
          if (step_r == LAST_DIGIT) begin
            state_r <= S_DADD;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_DADD: state_r <= S_PUT;
        S_PUT: begin
          if (put) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `DRPI_CHECK_NEXT(a_accept_dispatch, accept, state_r == S_DISPATCH, "accepted word not dispatched")
  `DRPI_CHECK_NEXT(a_result_held, (state_r == S_PUT) && out_valid_r && out_stall, state_r == S_PUT, "result left while output full")
  `DRPI_CHECK_NOW(a_step_range, state_r == S_CSTEP, step_r <= LAST_STEP, "cordic step out of range")
  `DRPI_CHECK_NEXT(a_axis_order, (state_r == S_ACC) && !axis_r, (state_r == S_MUL) && axis_r, "y axis not started after x")

endmodule

### rtl/core/dead_reckoning_pose_integrator_top.sv
// top level of the dead-reckoning pose integrator
// Usage: one rover command word enters on in_valid/in_stall (in_word), and
// exactly one pose word per command leaves on out_valid/out_stall (out_word).
// A command is taken when in_valid is high and in_stall is low; in_stall stays
// high while a command is in work. start_x and start_y are written over the
// APB-style port at byte addresses 0 and 8 and read back sign-extended.
// An advance runs the cordic steps, then the x and y scaling passes in turn; a
// degree turn runs the radix-4 divide-by-360 unit, a radian turn the two
// narrow products and the heading add, and analysis goes straight to output.
// A new command is taken only once the last one is through, since the single
// shared cordic add/shift unit and the scaling passes serve one at a time.
// The finished word sits in an output register, so the next command is taken
// while it waits; if out_stall stays high, the following result waits in the
// controller and no further command is taken until the register frees.
// Synchronous reset clears pose, heading, start registers and out_valid.
module dead_reckoning_pose_integrator_top #(
  parameter int CORDIC_STEPS = drpi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  drpi_pkg::in_word_t                   in_word,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output drpi_pkg::out_word_t                  out_word,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [drpi_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [drpi_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [drpi_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import drpi_pkg::*;

  logic signed [POS_W-1:0] start_x_r, start_y_r;
  logic                    cfg_we;
  dp_cmd_t                 cmd;
  dp_stat_t                stat;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
    end else if (cfg_we) begin
      case (paddr[REG_SEL_BIT])
        REG_START_X: start_x_r <= pwdata[POS_W-1:0];
        REG_START_Y: start_y_r <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[REG_SEL_BIT])
      REG_START_X: prdata = {{(CFG_DATA_W-POS_W){start_x_r[POS_W-1]}}, start_x_r};
      REG_START_Y: prdata = {{(CFG_DATA_W-POS_W){start_y_r[POS_W-1]}}, start_y_r};
      default:     prdata = '0;
    endcase
  end

  drpi_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  drpi_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .start_x  (start_x_r),
    .start_y  (start_y_r),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule
